@@ hdl/lpa_pkg.sv @@
// ----------------------------------------------------------------------------
// lpa_pkg
// Shared types and constants for the lookback payoff accumulator.
// ----------------------------------------------------------------------------
package lpa_pkg;

	localparam int PRICE_BITS_DEF = 32;
	localparam int SUM_BITS_DEF   = 64;
	localparam int COUNT_BITS_DEF = 32;

	localparam int FIELD_BITS   = 32;
	localparam int DISC_BITS    = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_STRIKE_STYLE    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CALL_OR_PUT     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STRIKE_PRICE    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DISCOUNT_FACTOR = 2'd3;

	localparam logic [DISC_BITS-1:0] DISC_RESET = 16'h8000;

	typedef struct packed {
		logic [FIELD_BITS-1:0] price_sample;
		logic                  last_in_path;
		logic                  last_in_batch;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] discounted_price;
		logic [FIELD_BITS-1:0] paths_counted;
		logic                  sum_saturated;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_PAYOFF,
		ST_ACCUM,
		ST_START,
		ST_DIVIDE,
		ST_SCALE,
		ST_DELIVER
	} lpa_state_t;

endpackage

@@ hdl/lpa_divider.sv @@
// ----------------------------------------------------------------------------
// lpa_divider
// Restoring radix-2 divider, one quotient bit per cycle through one
// shared subtractor. done pulses for one cycle when quotient is valid.
// ----------------------------------------------------------------------------
module lpa_divider #(
	parameter int SUM_BITS   = lpa_pkg::SUM_BITS_DEF,
	parameter int COUNT_BITS = lpa_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SUM_BITS-1:0]   dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  done,
	output logic [SUM_BITS-1:0]   quotient
);
	localparam int STEP_BITS = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [COUNT_BITS:0]   rem_q;
	logic [SUM_BITS-1:0]   quot_q;
	logic [COUNT_BITS-1:0] dsr_q;

	logic [COUNT_BITS:0]   rem_sh;
	logic [COUNT_BITS:0]   rem_diff;
	logic                  fits;

	always_comb begin
		rem_sh   = {rem_q[COUNT_BITS-1:0], quot_q[SUM_BITS-1]};
		rem_diff = rem_sh - {1'b0, dsr_q};
		fits     = rem_sh >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(SUM_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_diff : rem_sh;
			quot_q <= {quot_q[SUM_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

@@ hdl/lookback_payoff_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// lookback_payoff_accumulator_unit
// Tracks path extremes, accumulates lookback payoffs with saturation and
// emits the discounted mean payoff at each batch end.
// ----------------------------------------------------------------------------
//  channel | signals                          | moves
//  in      | in_valid, in_stall, in_item      | one price sample request
//  out     | out_valid, out_stall, out_item   | one batch result
//  cfg     | cfg_we, cfg_index, cfg_data      | register write, no wait
//
//  Plain sample: IDLE, UPDATE. Path end adds PAYOFF, ACCUM. Batch end adds
//  START, DIVIDE (bit-serial, one quotient bit per cycle), SCALE, DELIVER.
//  in_stall is high whenever the sequencer is not idle.
//  Results sit in an output register; a stalled result holds the sequencer
//  only when the next one is ready to be loaded.
//  Reset returns registers and path/batch state to their initial values.
// ----------------------------------------------------------------------------
module lookback_payoff_accumulator_unit #(
	parameter int PRICE_BITS = lpa_pkg::PRICE_BITS_DEF,
	parameter int SUM_BITS   = lpa_pkg::SUM_BITS_DEF,
	parameter int COUNT_BITS = lpa_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  lpa_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output lpa_pkg::out_item_t                  out_item,
	input  logic                                cfg_we,
	input  logic [lpa_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [lpa_pkg::FIELD_BITS-1:0]      cfg_data
);
	import lpa_pkg::*;

	// samples are 32 bits wide, so wider price masks have no effect
	localparam int PW = (PRICE_BITS < FIELD_BITS) ? PRICE_BITS : FIELD_BITS;
	localparam int PROD_BITS = SUM_BITS + DISC_BITS;

	lpa_state_t state_q, state_d;

	logic                  strike_style_q;
	logic                  call_or_put_q;
	logic [PW-1:0]         strike_q;
	logic [DISC_BITS-1:0]  disc_q;

	logic [PW-1:0]         sample_q;
	logic                  end_path_q;
	logic                  end_batch_q;
	logic [PW-1:0]         min_q;
	logic [PW-1:0]         max_q;
	logic [PW-1:0]         payoff_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  sat_q;
	logic [PROD_BITS-1:0]  prod_q;

	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  in_take;
	logic                  out_free;
	logic                  out_load;
	logic                  div_start;
	logic                  div_done;
	logic [SUM_BITS-1:0]   div_quot;

	logic [PW-1:0]         payoff_d;
	logic [SUM_BITS:0]     sum_ext;
	logic [SUM_BITS:0]     scaled;
	logic [FIELD_BITS-1:0] result;

	lpa_divider #(
		.SUM_BITS  (SUM_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (count_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_take  = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_UPDATE;
			ST_UPDATE:  state_d = (end_path_q || end_batch_q) ? ST_PAYOFF : ST_IDLE;
			ST_PAYOFF:  state_d = ST_ACCUM;
			ST_ACCUM:   state_d = end_batch_q ? ST_START : ST_IDLE;
			ST_START:   state_d = ST_DIVIDE;
			ST_DIVIDE:  if (div_done) state_d = ST_SCALE;
			ST_SCALE:   state_d = ST_DELIVER;
			ST_DELIVER: if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:    in_stall  = 1'b0;
			// divider loads sum and count after the last path is added
			ST_START:   div_start = 1'b1;
			ST_DELIVER: out_load  = out_free;
			default:    ;
		endcase
	end

	// payoff from the updated extremes
	always_comb begin
		payoff_d = '0;
		case ({strike_style_q, call_or_put_q})
			2'b00:   if (sample_q > min_q)  payoff_d = sample_q - min_q;
			2'b01:   if (max_q > sample_q)  payoff_d = max_q - sample_q;
			2'b10:   if (max_q > strike_q)  payoff_d = max_q - strike_q;
			2'b11:   if (strike_q > min_q)  payoff_d = strike_q - min_q;
			default: payoff_d = '0;
		endcase
	end

	always_comb begin
		sum_ext = {1'b0, sum_q} + (SUM_BITS + 1)'(payoff_q);
		scaled  = prod_q[PROD_BITS-1:DISC_BITS-1];
		result  = (|scaled[SUM_BITS:FIELD_BITS]) ? '1 : scaled[FIELD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			strike_style_q <= 1'b0;
			call_or_put_q  <= 1'b0;
			strike_q       <= '0;
			disc_q         <= DISC_RESET;
			end_path_q     <= 1'b0;
			end_batch_q    <= 1'b0;
			min_q          <= '1;
			max_q          <= '0;
			sum_q          <= '0;
			count_q        <= '0;
			sat_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					CFG_STRIKE_STYLE:    strike_style_q <= cfg_data[0];
					CFG_CALL_OR_PUT:     call_or_put_q  <= cfg_data[0];
					CFG_STRIKE_PRICE:    strike_q       <= cfg_data[PW-1:0];
					CFG_DISCOUNT_FACTOR: disc_q         <= cfg_data[DISC_BITS-1:0];
					default:             ;
				endcase
			end

			if (in_take) begin
				end_path_q  <= in_item.last_in_path;
				end_batch_q <= in_item.last_in_batch;
			end

			case (state_q)
				ST_UPDATE: begin
					if (sample_q < min_q) min_q <= sample_q;
					if (sample_q > max_q) max_q <= sample_q;
				end
				ST_ACCUM: begin
					if (sum_ext[SUM_BITS]) begin
						sum_q <= '1;
						sat_q <= 1'b1;
					end else begin
						sum_q <= sum_ext[SUM_BITS-1:0];
					end
					if (&count_q) begin
						sat_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
					min_q <= '1;
					max_q <= '0;
				end
				ST_DELIVER: begin
					if (out_free) begin
						sum_q   <= '0;
						count_q <= '0;
						sat_q   <= 1'b0;
					end
				end
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= in_item.price_sample[PW-1:0];
		end
		if (state_q == ST_PAYOFF) begin
			payoff_q <= payoff_d;
		end
		if (state_q == ST_SCALE) begin
			prod_q <= PROD_BITS'(div_quot) * PROD_BITS'(disc_q);
		end
		if (out_load) begin
			out_q.discounted_price <= result;
			out_q.paths_counted    <= FIELD_BITS'(count_q);
			out_q.sum_saturated    <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
